>>> sv/ssm_pkg.sv
// shared types and constants for the sequence stall monitor
package ssm_pkg;

  localparam int unsigned SeqW  = 32;
  localparam int unsigned TimeW = 32;
  localparam int unsigned DupW  = 32;
  localparam int unsigned CfgW  = 32;
  localparam int unsigned AddrW = 3;

  localparam logic [CfgW-1:0] StallThresholdReset = 32'd60000;
  localparam logic [DupW-1:0] DupMax              = 32'hFFFF_FFFF;

  // register index of the stall threshold
  localparam logic [AddrW-3:0] RegStallThreshold = 1'b0;

  typedef enum logic [2:0] {
    EV_IGNORED   = 3'd0,
    EV_FIRST     = 3'd1,
    EV_ADVANCE   = 3'd2,
    EV_DUPLICATE = 3'd3,
    EV_RESTART   = 3'd4
  } ev_kind_e;

  typedef struct packed {
    logic             seen_any;
    logic [SeqW-1:0]  last_seq;
    logic [TimeW-1:0] adv_time;
    logic [TimeW-1:0] rcv_time;
    logic [DupW-1:0]  rep_cnt;
  } trk_state_t;

  typedef struct packed {
    logic            stuck;
    ev_kind_e        kind;
    logic [DupW-1:0] dup_cnt;
    logic [SeqW-1:0] latest_seq;
    logic            tracking;
  } result_t;

endpackage

>>> sv/ssm_cfg.sv
// apb register block holding the stall threshold
module ssm_cfg
  import ssm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [CfgW-1:0]  pwdata,
  output logic [CfgW-1:0]  prdata,
  output logic             pready,
  output logic [CfgW-1:0]  thr_o
);

  logic [CfgW-1:0] thr_q, thr_d;
  logic            sel_thr;

  assign sel_thr = (paddr[AddrW-1:2] == RegStallThreshold);
  assign pready  = 1'b1;

  always_comb begin
    thr_d = thr_q;
    if (psel && penable && pwrite && sel_thr) begin
      thr_d = pwdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= StallThresholdReset;
    end else begin
      thr_q <= thr_d;
    end
  end

  assign prdata = sel_thr ? thr_q : '0;
  assign thr_o  = thr_q;

endmodule

>>> sv/ssm_update.sv
// per-word tracking update and stall check
module ssm_update
  import ssm_pkg::*;
(
  input  trk_state_t       st_i,
  input  logic [SeqW-1:0]  seq_i,
  input  logic [TimeW-1:0] now_i,
  input  logic [CfgW-1:0]  thr_i,
  output trk_state_t       st_o,
  output result_t          res_o
);

  trk_state_t      st_n;
  ev_kind_e        kind;
  logic [TimeW-1:0] elapsed;

  always_comb begin
    st_n = st_i;
    kind = EV_IGNORED;
    if (seq_i != '0) begin
      if (!st_i.seen_any) begin
        st_n.seen_any = 1'b1;
        st_n.last_seq = seq_i;
        st_n.adv_time = now_i;
        st_n.rcv_time = now_i;
        st_n.rep_cnt  = '0;
        kind          = EV_FIRST;
      end else begin
        st_n.rcv_time = now_i;
        if (seq_i > st_i.last_seq) begin
          st_n.last_seq = seq_i;
          st_n.adv_time = now_i;
          st_n.rep_cnt  = '0;
          kind          = EV_ADVANCE;
        end else if (seq_i == st_i.last_seq) begin
          if (st_i.rep_cnt != DupMax) begin
            st_n.rep_cnt = st_i.rep_cnt + 1'b1;
          end
          kind = EV_DUPLICATE;
        end else begin
          // lower number: node restarted, treat like an advance
          st_n.last_seq = seq_i;
          st_n.adv_time = now_i;
          st_n.rep_cnt  = '0;
          kind          = EV_RESTART;
        end
      end
    end
  end

  assign elapsed = now_i - st_n.adv_time;

  always_comb begin
    res_o.stuck      = st_n.seen_any && (st_n.adv_time != '0) &&
                       (now_i > st_n.adv_time) && (elapsed >= thr_i) &&
                       (st_n.rcv_time > st_n.adv_time) && (st_n.rep_cnt != '0);
    res_o.kind       = kind;
    res_o.dup_cnt    = st_n.rep_cnt;
    res_o.latest_seq = st_n.last_seq;
    res_o.tracking   = st_n.seen_any;
  end

  assign st_o = st_n;

endmodule

>>> sv/sequence_stall_monitor_core.sv
// top level of the sequence stall monitor
//
// input channel: one word per packet or query (sequence_number_i, time_ms_i);
// a zero sequence is a query that only runs the stall check. output channel:
// one result word per input word (stuck, event kind, duplicate count, latest
// sequence, tracking flag), in input order.
// an accepted word sits in the input register; once the result register is
// free or drains, the update writes the tracking state and result register.
// throughput is one word per cycle while the receiver does not stall, set by
// the combinational state update between the input and result registers.
// when the receiver stalls the result register holds; the input register
// still takes one more word, after which in_ready_o follows out_ready_i.
// reset clears the tracking state, both valid flags and sets the threshold
// to 60000 ms. the threshold must be written over the apb port only while
// idle; the block itself does not enforce this.
module sequence_stall_monitor_core
  import ssm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [CfgW-1:0]  pwdata,
  output logic [CfgW-1:0]  prdata,
  output logic             pready,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [SeqW-1:0]  sequence_number_i,
  input  logic [TimeW-1:0] time_ms_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             stuck_o,
  output logic [2:0]       event_kind_o,
  output logic [DupW-1:0]  duplicate_count_o,
  output logic [SeqW-1:0]  latest_sequence_o,
  output logic             tracking_o
);

  logic [CfgW-1:0]  thr;
  logic             s1_valid_q, s1_valid_d;
  logic [SeqW-1:0]  s1_seq_q;
  logic [TimeW-1:0] s1_time_q;
  logic             s2_valid_q, s2_valid_d;
  result_t          s2_res_q, res;
  trk_state_t       st_q, st_d;
  logic             s2_load, in_acc;

  ssm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .thr_o   (thr)
  );

  ssm_update u_update (
    .st_i  (st_q),
    .seq_i (s1_seq_q),
    .now_i (s1_time_q),
    .thr_i (thr),
    .st_o  (st_d),
    .res_o (res)
  );

  assign s2_load    = s1_valid_q && (!s2_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s2_load;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s2_load) begin
      s1_valid_d = 1'b0;
    end
    s2_valid_d = s2_valid_q;
    if (s2_load) begin
      s2_valid_d = 1'b1;
    end else if (out_ready_i) begin
      s2_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      st_q       <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
      if (s2_load) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_seq_q  <= sequence_number_i;
      s1_time_q <= time_ms_i;
    end
    if (s2_load) begin
      s2_res_q <= res;
    end
  end

  assign out_valid_o       = s2_valid_q;
  assign stuck_o           = s2_res_q.stuck;
  assign event_kind_o      = s2_res_q.kind;
  assign duplicate_count_o = s2_res_q.dup_cnt;
  assign latest_sequence_o = s2_res_q.latest_seq;
  assign tracking_o        = s2_res_q.tracking;

endmodule

>>> sv/ssm_checker.sv
// port-level checks for the sequence stall monitor, bound to the top level
module ssm_checker
  import ssm_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic             stuck_o,
  input logic [2:0]       event_kind_o,
  input logic [DupW-1:0]  duplicate_count_o,
  input logic [SeqW-1:0]  latest_sequence_o,
  input logic             tracking_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(event_kind_o) &&
      $stable(duplicate_count_o) && $stable(latest_sequence_o) && $stable(stuck_o))
    else $error("result word changed while stalled");

  // stuck needs tracking and at least one duplicate
  a_stuck_cond: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stuck_o |-> tracking_o && (duplicate_count_o != '0))
    else $error("stuck without tracking or duplicates");

  // first seen, advance and restart clear the duplicate count and never stall
  a_reset_dup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o == EV_FIRST || event_kind_o == EV_ADVANCE ||
      event_kind_o == EV_RESTART) |-> (duplicate_count_o == '0) && !stuck_o &&
      tracking_o && (latest_sequence_o != '0))
    else $error("sequence event left duplicates or stall");

  // no tracking means nothing was recorded
  a_idle_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !tracking_o |-> (event_kind_o == EV_IGNORED) &&
      (latest_sequence_o == '0) && (duplicate_count_o == '0))
    else $error("state recorded before tracking");

endmodule

bind sequence_stall_monitor_core ssm_checker u_ssm_checker (.*);
